### src/srr_pkg.sv
// Shared types, constants and helpers for the selective-repeat receiver.
package srr_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int MAX_WINDOW   = 32;
    localparam int WIN_CAP      = (WINDOW_DEPTH < MAX_WINDOW) ? WINDOW_DEPTH : MAX_WINDOW;
    localparam int CFG_W        = 6;
    localparam int W_W          = $clog2(WIN_CAP + 1);
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SEQ_W        = 32;
    localparam int TAG_W        = 16;
    localparam int CNT_W        = $clog2(SEQ_W);
    localparam int SLOT_W       = TAG_W + 1;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_SREJ    = 2'd1,
        KIND_DUP     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_INORDER   = 2'd0,
        MODE_BUFFERING = 2'd1,
        MODE_FLUSHING  = 2'd2
    } t_rx_mode;

    typedef enum logic [1:0] {
        SRC_DUP  = 2'd0,
        SRC_ITEM = 2'd1,
        SRC_SREJ = 2'd2,
        SRC_SLOT = 2'd3
    } t_emit_src;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_number;
        logic             checksum_ok;
        logic             is_last;
        logic [TAG_W-1:0] payload_tag;
    } t_srr_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] ack_number;
        logic [TAG_W-1:0] deliver_tag;
        logic             transfer_done;
        logic             last_of_run;
    } t_srr_out;

    typedef struct packed {
        logic      load_item;
        logic      emit;
        t_emit_src emit_src;
        logic      emit_lor;
        logic      exp_from_item;
        logic      exp_inc;
        logic      set_finished;
        logic      high_from_item;
        logic      store;
        logic      clear_slot;
        logic      mode_we;
        t_rx_mode  mode_val;
        logic      iter_clr;
        logic      mod_start;
        logic      mod_step;
    } t_srr_cmd;

    typedef struct packed {
        logic ignore;
        logic is_old;
        logic beyond;
        logic is_exp;
        logic item_last;
        logic mode_inorder;
        logic mode_buffering;
        logic next_le_high;
        logic exp_le_high;
        logic exp1_le_high;
        logic iter_lt_w;
        logic iter1_lt_w;
        logic slot_hit;
        logic slot_last;
        logic out_free;
        logic mod_stale;
        logic mod_last;
    } t_srr_stat;

    // Clamp the programmed window size into 1..WIN_CAP.
    function automatic logic [W_W-1:0] eff_window(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] w;
        w = v;
        if (w == '0) w = CFG_W'(1);
        if (w > CFG_W'(WIN_CAP)) w = CFG_W'(WIN_CAP);
        return W_W'(w);
    endfunction

endpackage

### src/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/srr_datapath.sv
// Receiver datapath: sequence state, reorder window, remainder unit and result register.
module srr_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srr_pkg::t_srr_cmd  i_cmd,
    output srr_pkg::t_srr_stat o_stat,
    input  srr_pkg::t_srr_in   i_item,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output srr_pkg::t_srr_out  o_result
);
    import srr_pkg::*;

    t_srr_in           r_item;
    logic [SEQ_W-1:0]  r_exp, n_exp;
    logic [SEQ_W-1:0]  r_high;
    t_rx_mode          r_mode;
    logic              r_finished;
    logic [W_W-1:0]    r_win;
    logic              r_stale;
    logic [W_W-1:0]    r_exp_mod, n_exp_mod;
    logic [CNT_W-1:0]  r_mod_cnt;
    logic [W_W:0]      r_iter;
    logic [WINDOW_DEPTH-1:0] r_valid;
    logic              r_out_valid;
    t_srr_out          r_out, n_out;

    logic [SEQ_W-1:0]  seq_p1, exp_p1, diff;
    logic [W_W:0]      inc_mod, slot_sum, slot_fix, mod_shift;
    logic [IDX_W-1:0]  exp_idx, store_idx;
    logic [SLOT_W-1:0] ram_rdata;
    logic              out_free;

    assign seq_p1  = r_item.seq_number + SEQ_W'(1);
    assign exp_p1  = r_exp + SEQ_W'(1);
    assign diff    = r_item.seq_number - r_exp;
    assign exp_idx = IDX_W'(r_exp_mod);
    assign out_free = !r_out_valid || !i_out_stall;

    // Slot of an item ahead of expected: (exp mod w) + diff, less w if it reaches w; diff below w.
    assign slot_sum  = {1'b0, r_exp_mod} + (W_W+1)'(diff[W_W-1:0]);
    assign slot_fix  = (slot_sum >= {1'b0, r_win}) ? slot_sum - {1'b0, r_win} : slot_sum;
    assign store_idx = IDX_W'(slot_fix);

    assign inc_mod   = {1'b0, r_exp_mod} + (W_W+1)'(1);
    // One remainder digit per cycle, MSB first.
    assign mod_shift = {r_exp_mod, r_exp[r_mod_cnt]};

    always_comb begin
        n_exp     = r_exp;
        n_exp_mod = r_exp_mod;
        if (i_cmd.exp_from_item || i_cmd.exp_inc) begin
            n_exp = exp_p1;
            if (r_exp == '1 || inc_mod == {1'b0, r_win}) begin
                n_exp_mod = '0;
            end else begin
                n_exp_mod = W_W'(inc_mod);
            end
        end else if (i_cmd.mod_start) begin
            n_exp_mod = '0;
        end else if (i_cmd.mod_step) begin
            if (mod_shift >= {1'b0, r_win}) begin
                n_exp_mod = W_W'(mod_shift - {1'b0, r_win});
            end else begin
                n_exp_mod = W_W'(mod_shift);
            end
        end
    end

    always_comb begin
        n_out = '0;
        case (i_cmd.emit_src)
            SRC_DUP: begin
                n_out.kind       = KIND_DUP;
                n_out.ack_number = r_exp - SEQ_W'(1);
            end
            SRC_ITEM: begin
                n_out.kind          = KIND_DELIVER;
                n_out.ack_number    = r_item.seq_number;
                n_out.deliver_tag   = r_item.payload_tag;
                n_out.transfer_done = r_item.is_last;
            end
            SRC_SREJ: begin
                n_out.kind       = KIND_SREJ;
                n_out.ack_number = r_exp;
            end
            SRC_SLOT: begin
                n_out.kind          = KIND_DELIVER;
                n_out.ack_number    = r_exp;
                n_out.deliver_tag   = ram_rdata[TAG_W-1:0];
                n_out.transfer_done = ram_rdata[TAG_W];
            end
            default: begin
                n_out = '0;
            end
        endcase
        n_out.last_of_run = i_cmd.emit_lor;
    end

    srr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (store_idx),
        .i_wdata ({r_item.is_last, r_item.payload_tag}),
        .i_raddr (exp_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp       <= '0;
            r_high      <= '0;
            r_mode      <= MODE_INORDER;
            r_finished  <= 1'b0;
            r_win       <= W_W'(WIN_CAP);
            r_stale     <= 1'b0;
            r_exp_mod   <= '0;
            r_mod_cnt   <= '0;
            r_iter      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_exp     <= n_exp;
            r_exp_mod <= n_exp_mod;
            if (i_cfg_we) begin
                r_win   <= eff_window(i_cfg_data);
                r_stale <= 1'b1;
            end else if (i_cmd.mod_step && r_mod_cnt == '0) begin
                r_stale <= 1'b0;
            end
            if (i_cmd.mod_start) begin
                r_mod_cnt <= CNT_W'(SEQ_W - 1);
            end else if (i_cmd.mod_step) begin
                r_mod_cnt <= r_mod_cnt - CNT_W'(1);
            end
            if (i_cmd.iter_clr) begin
                r_iter <= '0;
            end else if (i_cmd.exp_inc) begin
                r_iter <= r_iter + (W_W+1)'(1);
            end
            if (i_cmd.set_finished) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.mode_we) begin
                r_mode <= i_cmd.mode_val;
            end
            if (i_cmd.high_from_item) begin
                r_high <= r_item.seq_number;
            end else if (i_cmd.store && r_item.seq_number > r_high) begin
                r_high <= r_item.seq_number;
            end
            if (i_cmd.store) begin
                r_valid[store_idx] <= 1'b1;
            end else if (i_cmd.clear_slot) begin
                r_valid[exp_idx] <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.ignore         = r_finished || !r_item.checksum_ok;
        o_stat.is_old         = r_item.seq_number < r_exp;
        o_stat.beyond         = diff >= SEQ_W'(r_win);
        o_stat.is_exp         = r_item.seq_number == r_exp;
        o_stat.item_last      = r_item.is_last;
        o_stat.mode_inorder   = r_mode == MODE_INORDER;
        o_stat.mode_buffering = r_mode == MODE_BUFFERING;
        o_stat.next_le_high   = seq_p1 <= r_high;
        o_stat.exp_le_high    = r_exp <= r_high;
        o_stat.exp1_le_high   = exp_p1 <= r_high;
        o_stat.iter_lt_w      = r_iter < {1'b0, r_win};
        o_stat.iter1_lt_w     = (r_iter + (W_W+1)'(1)) < {1'b0, r_win};
        o_stat.slot_hit       = r_valid[exp_idx];
        o_stat.slot_last      = ram_rdata[TAG_W];
        o_stat.out_free       = out_free;
        o_stat.mod_stale      = r_stale;
        o_stat.mod_last       = r_mod_cnt == '0;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

### src/srr_ctrl.sv
// Receiver controller: sequences classify, store, flush and remainder rebuild.
module srr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  srr_pkg::t_srr_stat i_stat,
    output srr_pkg::t_srr_cmd  o_cmd,
    output logic               o_in_stall
);
    import srr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MOD    = 5'b00010,
        ST_EVAL   = 5'b00100,
        ST_FL_RD  = 5'b01000,
        ST_FL_CHK = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    if (i_stat.mod_stale) begin
                        o_cmd.mod_start = 1'b1;
                        n_state = ST_MOD;
                    end else begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_stat.ignore) begin
                    n_state = ST_IDLE;
                end else if (i_stat.is_old) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = SRC_DUP;
                        o_cmd.emit_lor = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (i_stat.beyond) begin
                    n_state = ST_IDLE;
                end else if (i_stat.is_exp) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit          = 1'b1;
                        o_cmd.emit_src      = SRC_ITEM;
                        o_cmd.exp_from_item = 1'b1;
                        n_state = ST_IDLE;
                        if (i_stat.item_last) begin
                            o_cmd.set_finished = 1'b1;
                            o_cmd.emit_lor     = 1'b1;
                        end else if (i_stat.mode_inorder) begin
                            o_cmd.high_from_item = 1'b1;
                            o_cmd.emit_lor       = 1'b1;
                        end else if (i_stat.next_le_high) begin
                            // gap filled with entries parked behind it: flush
                            o_cmd.mode_we  = 1'b1;
                            o_cmd.mode_val = MODE_FLUSHING;
                            o_cmd.iter_clr = 1'b1;
                            n_state = ST_FL_RD;
                        end else begin
                            o_cmd.mode_we  = 1'b1;
                            o_cmd.mode_val = MODE_INORDER;
                            o_cmd.emit_lor = 1'b1;
                        end
                    end
                end else if (i_stat.mode_buffering) begin
                    o_cmd.store = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    // first packet past a gap: park it and request the missing one
                    o_cmd.store    = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = SRC_SREJ;
                    o_cmd.emit_lor = 1'b1;
                    o_cmd.mode_we  = 1'b1;
                    o_cmd.mode_val = MODE_BUFFERING;
                    n_state = ST_IDLE;
                end
            end
            ST_FL_RD: begin
                if (i_stat.exp_le_high && i_stat.iter_lt_w) begin
                    n_state = ST_FL_CHK;
                end else begin
                    o_cmd.mode_we  = 1'b1;
                    o_cmd.mode_val = i_stat.exp_le_high ? MODE_BUFFERING : MODE_INORDER;
                    n_state = ST_IDLE;
                end
            end
            ST_FL_CHK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.slot_hit) begin
                        o_cmd.emit_src   = SRC_SLOT;
                        o_cmd.clear_slot = 1'b1;
                        o_cmd.exp_inc    = 1'b1;
                        if (i_stat.slot_last) begin
                            o_cmd.set_finished = 1'b1;
                            o_cmd.emit_lor     = 1'b1;
                            n_state = ST_IDLE;
                        end else if (i_stat.exp1_le_high && i_stat.iter1_lt_w) begin
                            n_state = ST_FL_RD;
                        end else begin
                            // flush bound or end of parked range
                            o_cmd.emit_lor = 1'b1;
                            o_cmd.mode_we  = 1'b1;
                            o_cmd.mode_val = i_stat.exp1_le_high ? MODE_BUFFERING
                                                                 : MODE_INORDER;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        o_cmd.emit_src = SRC_SREJ;
                        o_cmd.emit_lor = 1'b1;
                        o_cmd.mode_we  = 1'b1;
                        o_cmd.mode_val = MODE_BUFFERING;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != ST_IDLE;

endmodule

### src/selective_repeat_receiver.sv
// Top level of the selective-repeat receiver: controller plus datapath.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_stall     i_in_item  (t_srr_in)
//   out       output     o_out_valid / i_out_stall   o_result   (t_srr_out)
//   cfg       input      i_cfg_we                    i_cfg_data (window size)
//
// A packet is accepted, then classified and answered once the result register
// is free. Filling a gap walks each flushed entry through a window RAM read,
// then a check and delivery. The first packet after a window size write waits
// while a bit-serial remainder rebuilds the expected slot index.
// Reset is synchronous, active low; the valid bits clear at once, no sweep.
// One result waits in the output register; a stalled output holds the block.
module selective_repeat_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  srr_pkg::t_srr_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output srr_pkg::t_srr_out o_result,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_data
);
    import srr_pkg::*;

    t_srr_cmd  cmd;
    t_srr_stat stat;

    srr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    srr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (o_result)
    );

endmodule

### sim/tb.sv
// Self-checking testbench for the selective-repeat receiver with a scoreboard of due acks.
`timescale 1ns / 1ps

module tb;
    import srr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned SETTLE_CYCLES = 120;

    // Tracks the receiver state and the acks and deliveries each request must produce.
    class ack_predictor;
        logic [5:0]  win_reg;
        t_rx_mode    mode;
        logic [31:0] exp_seq;
        logic [31:0] high_seq;
        bit          slot_v [32];
        logic [15:0] slot_t [32];
        bit          slot_l [32];
        bit          done;
        t_srr_out    acks_due [$];
        int          errors;

        function new();
            win_reg = 6'd32;
            mode = MODE_INORDER;
            exp_seq = '0;
            high_seq = '0;
            done = 1'b0;
            errors = 0;
            foreach (slot_v[i]) begin
                slot_v[i] = 1'b0;
                slot_t[i] = '0;
                slot_l[i] = 1'b0;
            end
        endfunction

        function int unsigned win_eff();
            int unsigned w;
            w = win_reg;
            if (w < 1) w = 1;
            if (w > 32) w = 32;
            if (w > WINDOW_DEPTH) w = WINDOW_DEPTH;
            return w;
        endfunction

        function t_srr_out ack(t_kind k, logic [31:0] num, logic [15:0] tag, logic fin);
            t_srr_out r;
            r.kind = k;
            r.ack_number = num;
            r.deliver_tag = tag;
            r.transfer_done = fin;
            r.last_of_run = 1'b0;
            return r;
        endfunction

        function void note_packet(t_srr_in p);
            t_srr_out    run [$];
            t_srr_out    r;
            int unsigned w;
            int unsigned iter;
            int unsigned idx;
            bit          l;
            w = win_eff();
            if (done || !p.checksum_ok) return;
            if (p.seq_number < exp_seq) begin
                run.push_back(ack(KIND_DUP, exp_seq - 32'd1, 16'd0, 1'b0));
            end else if (p.seq_number - exp_seq >= w) begin
                return;
            end else if (p.seq_number == exp_seq) begin
                run.push_back(ack(KIND_DELIVER, p.seq_number, p.payload_tag, p.is_last));
                exp_seq = p.seq_number + 32'd1;
                if (p.is_last) begin
                    done = 1'b1;
                end else if (mode == MODE_INORDER) begin
                    high_seq = p.seq_number;
                end else begin
                    iter = 0;
                    mode = MODE_FLUSHING;
                    // walk held entries until a hole, the end or the window bound
                    while (exp_seq <= high_seq && iter < w) begin
                        idx = exp_seq % w;
                        iter++;
                        if (slot_v[idx]) begin
                            l = slot_l[idx];
                            run.push_back(ack(KIND_DELIVER, exp_seq, slot_t[idx], l));
                            slot_v[idx] = 1'b0;
                            exp_seq = exp_seq + 32'd1;
                            if (l) begin
                                done = 1'b1;
                                break;
                            end
                        end else begin
                            run.push_back(ack(KIND_SREJ, exp_seq, 16'd0, 1'b0));
                            mode = MODE_BUFFERING;
                            break;
                        end
                    end
                    if (mode == MODE_FLUSHING && !done)
                        mode = (exp_seq <= high_seq) ? MODE_BUFFERING : MODE_INORDER;
                end
            end else begin
                idx = p.seq_number % w;
                if (mode != MODE_BUFFERING) begin
                    run.push_back(ack(KIND_SREJ, exp_seq, 16'd0, 1'b0));
                    mode = MODE_BUFFERING;
                end
                slot_v[idx] = 1'b1;
                slot_t[idx] = p.payload_tag;
                slot_l[idx] = p.is_last;
                if (p.seq_number > high_seq) high_seq = p.seq_number;
            end
            foreach (run[i]) begin
                r = run[i];
                r.last_of_run = (i == run.size() - 1);
                acks_due.push_back(r);
            end
        endfunction

        function void compare(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                errors++;
                $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(t_srr_out r);
            t_srr_out want;
            if (acks_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result: kind %0d ack %0h tag %0h done %0b last %0b",
                         $time, r.kind, r.ack_number, r.deliver_tag, r.transfer_done,
                         r.last_of_run);
                return;
            end
            want = acks_due.pop_front();
            compare("kind", 32'(r.kind), 32'(want.kind));
            compare("ack_number", r.ack_number, want.ack_number);
            compare("deliver_tag", 32'(r.deliver_tag), 32'(want.deliver_tag));
            compare("transfer_done", 32'(r.transfer_done), 32'(want.transfer_done));
            compare("last_of_run", 32'(r.last_of_run), 32'(want.last_of_run));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_srr_in    in_item;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_srr_out   result;
    logic       cfg_we;
    logic [5:0] cfg_data;

    ack_predictor rx_model;
    int unsigned  cycles = 0;
    int unsigned  items_sent = 0;
    int unsigned  hold_left = 0;
    bit           in_burst;
    bit           out_burst;
    logic [5:0]   win_plan [8] = '{6'd1, 6'd2, 6'd33, 6'd32, 6'd3, 6'd0, 6'd31, 6'd16};

    selective_repeat_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Hold the result channel for runs of random length.
    always @(negedge clk) begin
        if (hold_left > 0) hold_left--;
        else hold_left = pick_gap(out_burst);
        out_stall <= (hold_left > 0);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) rx_model.check_result(result);
    end

    function automatic t_srr_in pkt(logic [31:0] seq, logic ok, logic last, logic [15:0] tag);
        t_srr_in p;
        p.seq_number = seq;
        p.checksum_ok = ok;
        p.is_last = last;
        p.payload_tag = tag;
        return p;
    endfunction

    // Bad checksum, old, out-of-window or random request; last is kept only where it can never land.
    function automatic t_srr_in noise_pkt();
        t_srr_in     p;
        logic [31:0] e;
        int unsigned w;
        e = rx_model.exp_seq;
        w = rx_model.win_eff();
        p = pkt($urandom, 1'b1, 1'($urandom_range(0, 1)), 16'($urandom));
        case ($urandom_range(0, 3))
            0: p.checksum_ok = 1'b0;
            1: if (e != 0) p.seq_number = $urandom_range(0, e - 32'd1);
            2: p.seq_number = e + w + $urandom_range(0, 3);
            default: ;
        endcase
        if (p.checksum_ok && p.seq_number >= e && p.seq_number - e < w) p.is_last = 1'b0;
        return p;
    endfunction

    task automatic send(input t_srr_in p);
        int unsigned gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= p;
        do @(posedge clk); while (in_stall !== 1'b0);
        rx_model.note_packet(p);
        gap = pick_gap(in_burst);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop the request line and wait until every due ack has come and the block is quiet.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rx_model.acks_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [5:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        rx_model.win_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_checks();
        send(pkt(32'd0, 1'b1, 1'b0, 16'h0000));
        send(pkt(32'd1, 1'b0, 1'b1, 16'hFFFF));
        send(pkt(32'd0, 1'b1, 1'b1, 16'hFFFF));
        send(pkt(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF));
        send(pkt(32'd33, 1'b1, 1'b1, 16'h1234));
        // open a gap, overwrite a held entry, then fill it
        send(pkt(32'd3, 1'b1, 1'b0, 16'h0003));
        send(pkt(32'd3, 1'b1, 1'b0, 16'h0303));
        send(pkt(32'd2, 1'b1, 1'b0, 16'h0002));
        send(pkt(32'd1, 1'b1, 1'b0, 16'h0001));
        // hold entries at the window edge in slots 0..3, then flush into a hole
        send(pkt(32'd35, 1'b1, 1'b0, 16'h0035));
        send(pkt(32'd34, 1'b1, 1'b0, 16'h0034));
        send(pkt(32'd32, 1'b1, 1'b0, 16'h0032));
        send(pkt(32'd33, 1'b1, 1'b0, 16'h0033));
        send(pkt(32'd6, 1'b1, 1'b0, 16'h0006));
        send(pkt(32'd5, 1'b1, 1'b0, 16'h0005));
        send(pkt(32'd4, 1'b1, 1'b0, 16'h0004));
        // shrink the window: the flush stops at the bound below the highest parked number
        settle();
        write_window(6'd4);
        send(pkt(32'd7, 1'b1, 1'b0, 16'h0007));
        send(pkt(32'd12, 1'b1, 1'b0, 16'h000C));
        settle();
        write_window(6'd0);
        send(pkt(32'd14, 1'b1, 1'b0, 16'h000E));
        send(pkt(32'd13, 1'b1, 1'b0, 16'h000D));
        settle();
        write_window(6'd63);
    endtask

    // One stretch of sequence numbers from the expected one, sent in order or shuffled, with holes.
    task automatic run_block();
        logic [31:0] base;
        logic [31:0] t;
        logic [31:0] seqs [$];
        int          w;
        int          k;
        int          j;
        w = rx_model.win_eff();
        base = rx_model.exp_seq;
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w) :
                                          $urandom_range(1, (w < 6) ? w : 6);
        for (int i = 0; i < k; i++) seqs.push_back(base + i);
        if ($urandom_range(0, 1) == 1) begin
            for (int i = k - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = seqs[i];
                seqs[i] = seqs[j];
                seqs[j] = t;
            end
        end
        foreach (seqs[i]) begin
            if ($urandom_range(0, 9) == 0) send(noise_pkt());
            if ($urandom_range(0, 7) != 0) begin
                send(pkt(seqs[i], 1'b1, 1'b0, 16'($urandom)));
                items_sent++;
                if ($urandom_range(0, 11) == 0) begin
                    send(pkt(seqs[i], 1'b1, 1'b0, 16'($urandom)));
                    items_sent++;
                end
            end
        end
        // fill the holes, or now and then leave entries held
        if ($urandom_range(0, 7) != 0) begin
            while (rx_model.exp_seq - base < k) begin
                send(pkt(rx_model.exp_seq, 1'b1, 1'b0, 16'($urandom)));
                items_sent++;
            end
        end
    endtask

    // Park the last packet ahead of a hole, fill the hole, then send into the finished block.
    task automatic close_transfer();
        logic [31:0] e;
        settle();
        write_window(6'd32);
        e = rx_model.exp_seq;
        send(pkt(e + 32'd1, 1'b1, 1'b1, 16'hFFFF));
        send(pkt(e, 1'b1, 1'b0, 16'($urandom)));
        send(pkt(e + 32'd2, 1'b1, 1'b0, 16'($urandom)));
        send(pkt(e, 1'b1, 1'b1, 16'($urandom)));
        send(pkt(32'd0, 1'b1, 1'b0, 16'h0000));
    endtask

    initial begin
        int unsigned phase;
        int unsigned start;
        rx_model = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_checks();
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            in_burst = ($urandom_range(0, 4) == 0);
            out_burst = ($urandom_range(0, 4) == 0);
            if (phase < 8) write_window(win_plan[phase]);
            else if ($urandom_range(0, 7) == 0) write_window(6'($urandom_range(0, 63)));
            else write_window(6'($urandom_range(2, 32)));
            phase++;
            start = items_sent;
            while (items_sent - start < 40 && items_sent < RANDOM_ITEMS) run_block();
        end
        close_transfer();
        settle();
        if (rx_model.errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule
